/* sv/totp_pkg.sv */
// ----------------------------------------------------------------------------
// totp_pkg: shared constants for the one-time password engine
// Register indexes, SHA-1 initial hash and round constants, powers of ten.
// ----------------------------------------------------------------------------
package totp_pkg;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEYLEN = 3'd3;
    localparam logic [2:0] REG_STEP   = 3'd4;
    localparam logic [2:0] REG_DIGITS = 3'd5;
    localparam logic [2:0] REG_WINDOW = 3'd6;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    localparam logic [31:0] SHA1_K0 = 32'h5A827999;
    localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

    localparam logic [31:0] MATCH_MODULUS = 32'd1000000;

    typedef logic [29:0] pow_t;

    function automatic pow_t pow_ten(input logic [3:0] d);
        pow_t p;
        case (d)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

/* sv/totp_code_engine.sv */
// ----------------------------------------------------------------------------
// totp_code_engine: time-based one-time password engine (HMAC-SHA1)
// Computes the code for a Unix time and checks a candidate over a window.
// ----------------------------------------------------------------------------
// Usage: write the key, key length, step, digit count and window through the
// cfg channel (cfg_ready is always high) while the engine is idle. Present a
// query on unix_seconds and candidate_code with start; it is taken when busy
// is low. Busy stays high until done pulses for one cycle with otp_value,
// seconds_left and code_match; the receiver cannot stall, so the result beat
// must be taken in the done cycle (code_match clears when the next query is
// taken).
// Each HMAC evaluation runs four SHA-1 blocks of 80 rounds on one shared
// round unit; each division or modulo runs on one shared restoring
// divider. A query costs one HMAC for the code plus up to 2*window+1 HMACs
// for the match, each with its division and modulo; the search stops at
// the first match.
// Reset returns the configuration registers to their defaults and the engine
// to idle.
// ----------------------------------------------------------------------------
module totp_code_engine #(
    parameter int KEY_BYTES  = 20,
    parameter int MAX_WINDOW = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [62:0] unix_seconds,
    input  logic [19:0] candidate_code,
    output logic        done,
    output logic [29:0] otp_value,
    output logic [31:0] seconds_left,
    output logic        code_match
);

    localparam int WW = (MAX_WINDOW > 0) ? $clog2(MAX_WINDOW + 1) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_HMAC   = 3'd2;
    localparam logic [2:0] ST_MOD    = 3'd3;
    localparam logic [2:0] ST_BACK   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [63:0] key0_reg, key1_reg;
    logic [31:0] key2_reg, step_reg;
    logic [4:0]  klen_reg;
    logic [3:0]  dig_reg;
    logic [2:0]  win_reg;

    logic [2:0]   state_reg;
    logic         main_reg;
    logic [63:0]  tw_reg, ctr_reg;
    logic [19:0]  cand_reg;
    logic [WW-1:0] back_reg;
    logic [WW:0]  iter_reg;
    logic [1:0]   blk_reg;
    logic         go_reg;
    logic [159:0] h_reg, ih_reg;
    logic [63:0]  div_q_reg;
    logic [31:0]  div_r_reg, div_d_reg;
    logic [6:0]   div_cnt_reg;
    logic         done_reg, match_reg;
    logic [29:0]  otp_reg;
    logic [31:0]  secl_reg;

    logic [31:0]   ts;
    logic [4:0]    klen;
    logic [3:0]    dig;
    logic [WW-1:0] win;
    logic [159:0]  key_m;
    logic [511:0]  blk;
    logic [159:0]  sha_h_in, sha_h_out;
    logic          sha_done;
    logic [32:0]   div_part;
    logic          div_ge;
    logic [3:0]    off;
    logic [31:0]   word;

    always_comb
    begin
        ts   = (step_reg == 32'd0) ? 32'd1 : step_reg;
        klen = (int'(klen_reg) > KEY_BYTES) ? 5'(KEY_BYTES) : klen_reg;
        dig  = (dig_reg > 4'd9) ? 4'd9 : dig_reg;
        win  = (int'(win_reg) > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(win_reg);
        key_m = {key0_reg, key1_reg, key2_reg};
        for (int i = 0; i < 20; i++)
            if (i >= int'(klen))
                key_m[159 - 8*i -: 8] = 8'h00;
        case (blk_reg)
            2'd0:    blk = {key_m, 352'b0} ^ {64{8'h36}};
            2'd1:    blk = {ctr_reg, 8'h80, 376'b0, 64'd576};
            2'd2:    blk = {key_m, 352'b0} ^ {64{8'h5C}};
            default: blk = {ih_reg, 8'h80, 280'b0, 64'd672};
        endcase
        sha_h_in = blk_reg[0] ? h_reg : totp_pkg::SHA1_IV;
        div_part = {div_r_reg, div_q_reg[63]};
        div_ge   = (div_part >= {1'b0, div_d_reg});
        off      = sha_h_out[3:0];
        word     = 32'(sha_h_out >> (8'd128 - {1'b0, off, 3'b000}));
    end

    totp_sha1 u_sha1 (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go_reg),
        .h_in  (sha_h_in),
        .block (blk),
        .done  (sha_done),
        .h_out (sha_h_out)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= 64'd0;
            key1_reg <= 64'd0;
            key2_reg <= 32'd0;
            klen_reg <= 5'd20;
            step_reg <= 32'd30;
            dig_reg  <= 4'd6;
            win_reg  <= 3'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                totp_pkg::REG_KEY0:   key0_reg <= cfg_data;
                totp_pkg::REG_KEY1:   key1_reg <= cfg_data;
                totp_pkg::REG_KEY2:   key2_reg <= cfg_data[31:0];
                totp_pkg::REG_KEYLEN: klen_reg <= cfg_data[4:0];
                totp_pkg::REG_STEP:   step_reg <= cfg_data[31:0];
                totp_pkg::REG_DIGITS: dig_reg  <= cfg_data[3:0];
                totp_pkg::REG_WINDOW: win_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            go_reg      <= 1'b0;
            div_cnt_reg <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            go_reg   <= 1'b0;
            if (div_cnt_reg != 7'd0)
            begin
                div_cnt_reg <= div_cnt_reg - 7'd1;
                div_q_reg   <= {div_q_reg[62:0], div_ge};
                div_r_reg   <= div_ge ? 32'(div_part - {1'b0, div_d_reg})
                                      : div_part[31:0];
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        tw_reg      <= {1'b0, unix_seconds};
                        cand_reg    <= candidate_code;
                        main_reg    <= 1'b1;
                        match_reg   <= 1'b0;
                        back_reg    <= win;
                        iter_reg    <= {win, 1'b1};
                        div_q_reg   <= {1'b0, unix_seconds};
                        div_r_reg   <= 32'd0;
                        div_d_reg   <= ts;
                        div_cnt_reg <= 7'd64;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_cnt_reg == 7'd0)
                    begin
                        if (main_reg)
                            secl_reg <= ts - div_r_reg;
                        ctr_reg   <= div_q_reg;
                        blk_reg   <= 2'd0;
                        go_reg    <= 1'b1;
                        state_reg <= ST_HMAC;
                    end
                end
                ST_HMAC:
                begin
                    if (sha_done)
                    begin
                        h_reg <= sha_h_out;
                        if (blk_reg == 2'd1)
                            ih_reg <= sha_h_out;
                        if (blk_reg == 2'd3)
                        begin
                            div_q_reg   <= {33'd0, word[30:0]};
                            div_r_reg   <= 32'd0;
                            div_d_reg   <= main_reg ? {2'b00, totp_pkg::pow_ten(dig)}
                                                    : totp_pkg::MATCH_MODULUS;
                            div_cnt_reg <= 7'd64;
                            state_reg   <= ST_MOD;
                        end
                        else
                        begin
                            blk_reg <= blk_reg + 2'd1;
                            go_reg  <= 1'b1;
                        end
                    end
                end
                ST_MOD:
                begin
                    if (div_cnt_reg == 7'd0)
                    begin
                        if (main_reg)
                        begin
                            otp_reg   <= div_r_reg[29:0];
                            main_reg  <= 1'b0;
                            state_reg <= ST_BACK;
                        end
                        else if (div_r_reg == {12'd0, cand_reg})
                        begin
                            match_reg <= 1'b1;
                            state_reg <= ST_FINISH;
                        end
                        else if (iter_reg == (WW+1)'(1))
                            state_reg <= ST_FINISH;
                        else
                        begin
                            iter_reg  <= iter_reg - (WW+1)'(1);
                            tw_reg    <= tw_reg + {32'd0, ts};
                            state_reg <= ST_BACK;
                        end
                    end
                end
                ST_BACK:
                begin
                    // Walks back to the oldest step of the window, then
                    // starts the division for the step in tw_reg.
                    if (back_reg != '0)
                    begin
                        tw_reg   <= tw_reg - {32'd0, ts};
                        back_reg <= back_reg - WW'(1);
                    end
                    else
                    begin
                        div_q_reg   <= tw_reg;
                        div_r_reg   <= 32'd0;
                        div_d_reg   <= ts;
                        div_cnt_reg <= 7'd64;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_FINISH:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg_ready    = 1'b1;
    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign otp_value    = otp_reg;
    assign seconds_left = secl_reg;
    assign code_match   = match_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE && $past(state_reg) == ST_FINISH))
        else $error("result strobe outside of finish");

    a_sha_in_hmac: assert property (@(posedge clk) disable iff (!rst_n)
        sha_done |-> (state_reg == ST_HMAC))
        else $error("hash block finished outside of HMAC phase");

    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != 7'd0) |-> (state_reg == ST_DIV || state_reg == ST_MOD))
        else $error("divider running outside of a divide phase");

    a_go_once: assert property (@(posedge clk) disable iff (!rst_n)
        go_reg |=> !go_reg)
        else $error("hash start held for more than one cycle");

endmodule

/* sv/totp_sha1.sv */
// ----------------------------------------------------------------------------
// totp_sha1: iterative SHA-1 block compression
// One 512-bit block per run, one round per clock, 80 rounds.
// ----------------------------------------------------------------------------
module totp_sha1 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [159:0] h_in,
    input  logic [511:0] block,
    output logic         done,
    output logic [159:0] h_out
);

    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [159:0] hs_reg;
    logic [31:0]  w_reg [16];
    logic [6:0]   rnd_reg;
    logic         run_reg;
    logic         done_reg;
    logic [31:0]  f, k, t, w_new;

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = totp_pkg::SHA1_K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = totp_pkg::SHA1_K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = totp_pkg::SHA1_K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = totp_pkg::SHA1_K3;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w_reg[0];
        w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                rnd_reg <= 7'd0;
            end
            else if (run_reg)
            begin
                rnd_reg <= rnd_reg + 7'd1;
                if (rnd_reg == 7'd79)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            hs_reg <= h_in;
            a_reg  <= h_in[159:128];
            b_reg  <= h_in[127:96];
            c_reg  <= h_in[95:64];
            d_reg  <= h_in[63:32];
            e_reg  <= h_in[31:0];
            for (int j = 0; j < 16; j++)
                w_reg[j] <= block[511 - 32*j -: 32];
        end
        else if (run_reg)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t;
            for (int j = 0; j < 15; j++)
                w_reg[j] <= w_reg[j+1];
            w_reg[15] <= w_new;
        end
    end

    assign done  = done_reg;
    assign h_out = {hs_reg[159:128] + a_reg, hs_reg[127:96] + b_reg,
                    hs_reg[95:64] + c_reg, hs_reg[63:32] + d_reg,
                    hs_reg[31:0] + e_reg};

endmodule
